@@ hw/rtl/gradient_optimizer_update_assert.svh @@
// Assertion macros for the gradient optimizer update block.
`ifndef GRADIENT_OPTIMIZER_UPDATE_ASSERT_SVH
`define GRADIENT_OPTIMIZER_UPDATE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define GOU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define GOU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GOU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GOU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/gou_pkg.sv @@
package gou_pkg;

    // Sizes of the state stores and of the item fields
    localparam int unsigned PARAM_COUNT = 4096;
    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Squared gradient: bits of g*g kept before the Q8.24 clip
    localparam int SQ_TOP     = 62;
    localparam int SQ_KEEP_W  = SQ_TOP - 24 + 1;

    // Square root pipeline: one result bit per stage
    localparam int ROOT_W     = 28;
    localparam int SQ_STEPS   = ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 2;

    // Divider pipeline: one quotient bit per stage
    localparam int DIV_STEPS  = 32;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int PROD_W     = FRAC_W + 1 + DATA_W;
    localparam int MAG_W      = PROD_W - 1;
    localparam int NUM_W      = 56;
    localparam int NUM_SHIFT  = NUM_W - MAG_W;

    // Saturation bounds of a signed 32-bit result
    localparam logic [DATA_W-1:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_NEG_MAG = 32'h8000_0000;

    typedef enum logic [MODE_W-1:0] {
        MODE_SGD      = 2'd0,
        MODE_MOMENTUM = 2'd1,
        MODE_RMSPROP  = 2'd2,
        MODE_ADAM     = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 2'd0,
        REG_LEARN_RATE = 2'd1,
        REG_DECAY      = 2'd2
    } cfg_reg_t;

    localparam mode_t              MODE_RESET       = MODE_SGD;
    localparam logic [FRAC_W-1:0]  LEARN_RATE_RESET = 16'd655;
    localparam logic [FRAC_W-1:0]  DECAY_RESET      = 16'd58982;

    // Item leaving the state update stage
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] grad;
        logic signed [DATA_W-1:0] vel;
        logic [DATA_W-1:0]        sqavg;
        logic                     sat;
    } upd_t;

    // Side data carried along the square root pipeline
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [PROD_W-1:0] prod;
        logic                     use_div;
        logic                     sat;
    } sq_side_t;

    // Side data carried along the divider pipeline
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic              neg;
        logic              use_div;
        logic [DATA_W-1:0] simple_u;
        logic              sat;
    } div_side_t;

endpackage

@@ hw/rtl/gou_if.sv @@
interface gou_in_if import gou_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] gradient;

    modport source (output valid, output param_index, output gradient, input ready);
    modport sink   (input valid, input param_index, input gradient, output ready);
endinterface

interface gou_out_if import gou_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] update_amount;
    logic                     saturated;

    modport source (output valid, output out_index, output update_amount, output saturated,
                    input ready);
    modport sink   (input valid, input out_index, input update_amount, input saturated,
                    output ready);
endinterface

interface gou_cfg_if import gou_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/gradient_optimizer_update.sv @@
// Per-parameter optimizer step (SGD, momentum, RMSProp or Adam, chosen by the
// mode register). One gradient item is accepted per clock and one result item
// leaves per clock while the output is not stalled and no store sweep runs;
// each item passes through the state store read, the velocity and
// square-average update, the square root (one root bit per stage), the
// division (one quotient bit per stage) and the output register.
// Items for the same index may follow each other back to back; the newest
// state is forwarded into the update stage. After reset the two 4096-entry
// state stores are swept to zero with gradient ready held low; configuration
// writes are taken at any time, but must only be issued while no item is in
// flight.
`include "gradient_optimizer_update_assert.svh"

module gradient_optimizer_update
    import gou_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    gou_cfg_if.sink    cfg,
    gou_in_if.sink     grad,
    gou_out_if.source  upd
);

    mode_t             mode_reg;
    logic [FRAC_W-1:0] lr_reg;
    logic [FRAC_W-1:0] decay_reg;

    logic adv;
    logic fire;
    logic clear_busy;

    logic st_valid;
    upd_t st_upd;

    logic                     uses_vel;
    logic                     uses_div;
    logic signed [DATA_W-1:0] x_sel;
    sq_side_t                 sq_in_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;

    logic [DEN_W-1:0]         den;
    logic [PROD_W-1:0]        prod_abs;
    logic [NUM_W-1:0]         num;
    logic signed [PROD_W-1:0] prod_rnd;
    div_side_t                dv_in_side;

    logic                 dv_valid;
    logic [DIV_STEPS-1:0] dv_quo;
    logic                 dv_ovf;
    div_side_t            dv_side;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [DATA_W-1:0]    out_u_reg;
    logic                 out_sat_reg;
    logic [DATA_W-1:0]    u_next;
    logic                 sat_next;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            lr_reg    <= LEARN_RATE_RESET;
            decay_reg <= DECAY_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_MODE:       mode_reg  <= mode_t'(cfg.data[MODE_W-1:0]);
                REG_LEARN_RATE: lr_reg    <= cfg.data;
                REG_DECAY:      decay_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is free
    assign adv        = !out_valid_reg || upd.ready;
    assign grad.ready = adv && !clear_busy;
    assign fire       = grad.valid && grad.ready;

    gou_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (fire),
        .in_idx     (grad.param_index),
        .in_grad    (grad.gradient),
        .mode       (mode_reg),
        .decay      (decay_reg),
        .clear_busy (clear_busy),
        .out_valid  (st_valid),
        .out_upd    (st_upd)
    );

    // Scale the selected value by the learning rate
    assign uses_vel = (mode_reg == MODE_MOMENTUM) || (mode_reg == MODE_ADAM);
    assign uses_div = (mode_reg == MODE_RMSPROP) || (mode_reg == MODE_ADAM);
    assign x_sel    = uses_vel ? st_upd.vel : st_upd.grad;

    always_comb
    begin
        sq_in_side.idx     = st_upd.idx;
        sq_in_side.prod    = $signed({1'b0, lr_reg}) * x_sel;
        sq_in_side.use_div = uses_div;
        sq_in_side.sat     = st_upd.sat && uses_div;
    end

    gou_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (st_valid),
        .in_rad    (st_upd.sqavg),
        .in_side   (sq_in_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Build divisor sqrt+eps, rounded dividend, and the plain scaled result
    assign den      = DEN_W'(sq_root) + DEN_W'(1);
    assign prod_abs = sq_side.prod[PROD_W-1] ? PROD_W'(-sq_side.prod) : PROD_W'(sq_side.prod);
    assign num      = {prod_abs[MAG_W-1:0], NUM_SHIFT'(0)} + NUM_W'(den >> 1);
    assign prod_rnd = (sq_side.prod + PROD_W'(1 << (FRAC_W - 1))) >>> FRAC_W;

    always_comb
    begin
        dv_in_side.idx      = sq_side.idx;
        dv_in_side.neg      = sq_side.prod[PROD_W-1];
        dv_in_side.use_div  = sq_side.use_div;
        dv_in_side.simple_u = prod_rnd[DATA_W-1:0];
        dv_in_side.sat      = sq_side.sat;
    end

    gou_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_num    (num),
        .in_den    (den),
        .in_side   (dv_in_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side)
    );

    // Saturate and apply the sign
    always_comb
    begin
        u_next   = dv_side.simple_u;
        sat_next = dv_side.sat;
        if (dv_side.use_div)
        begin
            if (dv_side.neg)
            begin
                if (dv_ovf || (dv_quo > S32_NEG_MAG))
                begin
                    u_next   = S32_NEG_MAG;
                    sat_next = 1'b1;
                end
                else
                    u_next = DATA_W'(-dv_quo);
            end
            else
            begin
                if (dv_ovf || (dv_quo > S32_MAX))
                begin
                    u_next   = S32_MAX;
                    sat_next = 1'b1;
                end
                else
                    u_next = dv_quo;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_idx_reg <= dv_side.idx;
            out_u_reg   <= u_next;
            out_sat_reg <= sat_next;
        end
    end

    assign upd.valid         = out_valid_reg;
    assign upd.out_index     = out_idx_reg;
    assign upd.update_amount = out_u_reg;
    assign upd.saturated     = out_sat_reg;

    `GOU_ASSERT_IMP(a_clear_quiet, clk, rst_n, clear_busy, !upd.valid, "result during store sweep")
    `GOU_ASSERT_IMP(a_stall_blocks, clk, rst_n, upd.valid && !upd.ready, !grad.ready, "accept while output stalled")
    `GOU_ASSERT_NXT(a_clear_once, clk, rst_n, !clear_busy, !clear_busy, "store sweep restarted")

endmodule

@@ hw/rtl/gou_state.sv @@
module gou_state
    import gou_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [DATA_W-1:0] in_grad,
    input  mode_t                    mode,
    input  logic [FRAC_W-1:0]        decay,
    output logic                     clear_busy,
    output logic                     out_valid,
    output upd_t                     out_upd
);

    localparam int MEM_DEPTH = PARAM_COUNT;

    logic [DATA_W-1:0] vel_mem   [0:MEM_DEPTH-1];
    logic [DATA_W-1:0] sqavg_mem [0:MEM_DEPTH-1];

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;

    logic                     a_valid_reg;
    logic [IDX_W-1:0]         a_idx_reg;
    logic signed [DATA_W-1:0] a_grad_reg;
    logic                     a_ok_reg;
    logic                     a_hit_reg;
    logic [SQ_KEEP_W-1:0]     a_sq_reg;
    logic [DATA_W-1:0]        vel_rd_reg;
    logic [DATA_W-1:0]        sqavg_rd_reg;

    logic b_valid_reg;
    upd_t b_upd_reg;

    logic signed [2*DATA_W-1:0] grad_sq;
    logic                       in_ok;
    logic                       in_hit;

    logic signed [DATA_W-1:0] v_old;
    logic [DATA_W-1:0]        s_old;
    logic [DATA_W-1:0]        sq_clip;
    logic                     sq_sat;
    logic [FRAC_W:0]          one_minus_b;
    logic signed [DATA_W:0]   dv;
    logic signed [DATA_W:0]   ds;
    logic signed [PROD_W+1:0] pv;
    logic signed [PROD_W+1:0] ps;
    logic signed [PROD_W+1:0] pv_rnd;
    logic signed [PROD_W+1:0] ps_rnd;
    logic signed [DATA_W-1:0] v_new;
    logic [DATA_W-1:0]        s_new;

    logic                     wr_vel;
    logic                     wr_sqavg;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_vel_data;
    logic [DATA_W-1:0]        wr_sqavg_data;

    // Square the gradient and look for a same-index item one stage ahead
    assign grad_sq = in_grad * in_grad;
    assign in_ok   = (32'(in_idx) < PARAM_COUNT);
    assign in_hit  = a_valid_reg && a_ok_reg && (a_idx_reg == in_idx);

    // Sweep the stores to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == IDX_W'(MEM_DEPTH - 1))
                clr_busy_reg <= 1'b0;
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign clear_busy = clr_busy_reg;

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_idx_reg  <= in_idx;
            a_grad_reg <= in_grad;
            a_ok_reg   <= in_ok;
            a_hit_reg  <= in_hit;
            a_sq_reg   <= grad_sq[SQ_TOP:24];
        end
    end

    // Pick stored state, or the newer value one stage ahead
    always_comb
    begin
        if (!a_ok_reg)
        begin
            v_old = '0;
            s_old = '0;
        end
        else if (a_hit_reg)
        begin
            v_old = b_upd_reg.vel;
            s_old = b_upd_reg.sqavg;
        end
        else
        begin
            v_old = $signed(vel_rd_reg);
            s_old = sqavg_rd_reg;
        end
    end

    // Clip g^2 to the unsigned Q8.24 range
    assign sq_sat  = |a_sq_reg[SQ_KEEP_W-1:DATA_W];
    assign sq_clip = sq_sat ? '1 : a_sq_reg[DATA_W-1:0];

    // Running averages: x + round((1-beta)*(new - x))
    assign one_minus_b = (FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(decay);
    assign dv      = {a_grad_reg[DATA_W-1], a_grad_reg} - {v_old[DATA_W-1], v_old};
    assign ds      = $signed({1'b0, sq_clip}) - $signed({1'b0, s_old});
    assign pv      = $signed({1'b0, one_minus_b}) * dv;
    assign ps      = $signed({1'b0, one_minus_b}) * ds;
    assign pv_rnd  = (pv + (PROD_W+2)'(1 << (FRAC_W - 1))) >>> FRAC_W;
    assign ps_rnd  = (ps + (PROD_W+2)'(1 << (FRAC_W - 1))) >>> FRAC_W;
    assign v_new   = v_old + pv_rnd[DATA_W-1:0];
    assign s_new   = s_old + ps_rnd[DATA_W-1:0];

    // Write back, or zero during the sweep
    always_comb
    begin
        if (clr_busy_reg)
        begin
            wr_vel        = 1'b1;
            wr_sqavg      = 1'b1;
            wr_addr       = clr_cnt_reg;
            wr_vel_data   = '0;
            wr_sqavg_data = '0;
        end
        else
        begin
            wr_vel        = adv && a_valid_reg && a_ok_reg &&
                            ((mode == MODE_MOMENTUM) || (mode == MODE_ADAM));
            wr_sqavg      = adv && a_valid_reg && a_ok_reg &&
                            ((mode == MODE_RMSPROP) || (mode == MODE_ADAM));
            wr_addr       = a_idx_reg;
            wr_vel_data   = v_new;
            wr_sqavg_data = s_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_vel)
            vel_mem[wr_addr] <= wr_vel_data;
        if (adv)
            vel_rd_reg <= vel_mem[in_idx];
    end

    always_ff @(posedge clk)
    begin
        if (wr_sqavg)
            sqavg_mem[wr_addr] <= wr_sqavg_data;
        if (adv)
            sqavg_rd_reg <= sqavg_mem[in_idx];
    end

    // Hold updated state for the next stage and for forwarding
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_upd_reg.idx   <= a_idx_reg;
            b_upd_reg.grad  <= a_grad_reg;
            b_upd_reg.vel   <= v_new;
            b_upd_reg.sqavg <= s_new;
            b_upd_reg.sat   <= sq_sat;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_upd   = b_upd_reg;

endmodule

@@ hw/rtl/gou_sqrt.sv @@
module gou_sqrt
    import gou_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_rad,
    input  sq_side_t          in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output sq_side_t          out_side
);

    // Radicand is in_rad * 2^24; each stage settles one root bit
    logic                vld_w  [0:SQ_STEPS];
    logic [DATA_W-1:0]   rad_w  [0:SQ_STEPS];
    logic [SQ_REM_W-1:0] rem_w  [0:SQ_STEPS];
    logic [ROOT_W-1:0]   root_w [0:SQ_STEPS];
    sq_side_t            side_w [0:SQ_STEPS];

    assign vld_w[0]  = in_valid;
    assign rad_w[0]  = in_rad;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign side_w[0] = in_side;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        logic                vld_reg;
        logic [DATA_W-1:0]   rad_reg;
        logic [SQ_REM_W-1:0] rem_reg;
        logic [ROOT_W-1:0]   root_reg;
        sq_side_t            side_reg;
        logic [1:0]          pair;
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] trial;

        // Bring down the next two radicand bits
        if (2 * k + 1 < DATA_W)
        begin : g_pair
            assign pair = rad_w[k][DATA_W-1-2*k -: 2];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        assign t     = {rem_w[k], pair};
        assign trial = (SQ_REM_W+2)'({root_w[k], 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg  <= rad_w[k];
                side_reg <= side_w[k];
                if (t >= trial)
                begin
                    rem_reg  <= SQ_REM_W'(t - trial);
                    root_reg <= {root_w[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= SQ_REM_W'(t);
                    root_reg <= {root_w[k][ROOT_W-2:0], 1'b0};
                end
            end
        end

        assign vld_w[k+1]  = vld_reg;
        assign rad_w[k+1]  = rad_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = vld_w[SQ_STEPS];
    assign out_root  = root_w[SQ_STEPS];
    assign out_side  = side_w[SQ_STEPS];

endmodule

@@ hw/rtl/gou_div.sv @@
module gou_div
    import gou_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     in_num,
    input  logic [DEN_W-1:0]     in_den,
    input  div_side_t            in_side,
    output logic                 out_valid,
    output logic [DIV_STEPS-1:0] out_quo,
    output logic                 out_ovf,
    output div_side_t            out_side
);

    // Restoring division, one quotient bit per stage
    logic                 vld_w  [0:DIV_STEPS];
    logic [DEN_W-1:0]     rem_w  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] lo_w   [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_w  [0:DIV_STEPS];
    logic [DEN_W-1:0]     den_w  [0:DIV_STEPS];
    logic                 ovf_w  [0:DIV_STEPS];
    div_side_t            side_w [0:DIV_STEPS];

    // Quotient needs more than 32 bits when the high part already reaches the divisor
    assign vld_w[0]  = in_valid;
    assign rem_w[0]  = DEN_W'(in_num[NUM_W-1:DIV_STEPS]);
    assign lo_w[0]   = in_num[DIV_STEPS-1:0];
    assign quo_w[0]  = '0;
    assign den_w[0]  = in_den;
    assign ovf_w[0]  = (DEN_W'(in_num[NUM_W-1:DIV_STEPS]) >= in_den);
    assign side_w[0] = in_side;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic                 vld_reg;
        logic [DEN_W-1:0]     rem_reg;
        logic [DIV_STEPS-1:0] lo_reg;
        logic [DIV_STEPS-1:0] quo_reg;
        logic [DEN_W-1:0]     den_reg;
        logic                 ovf_reg;
        div_side_t            side_reg;
        logic [DEN_W:0]       t;

        assign t = {rem_w[k], lo_w[k][DIV_STEPS-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (adv)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lo_reg   <= {lo_w[k][DIV_STEPS-2:0], 1'b0};
                den_reg  <= den_w[k];
                ovf_reg  <= ovf_w[k];
                side_reg <= side_w[k];
                if (t >= {1'b0, den_w[k]})
                begin
                    rem_reg <= DEN_W'(t - {1'b0, den_w[k]});
                    quo_reg <= {quo_w[k][DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= DEN_W'(t);
                    quo_reg <= {quo_w[k][DIV_STEPS-2:0], 1'b0};
                end
            end
        end

        assign vld_w[k+1]  = vld_reg;
        assign rem_w[k+1]  = rem_reg;
        assign lo_w[k+1]   = lo_reg;
        assign quo_w[k+1]  = quo_reg;
        assign den_w[k+1]  = den_reg;
        assign ovf_w[k+1]  = ovf_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_valid = vld_w[DIV_STEPS];
    assign out_quo   = quo_w[DIV_STEPS];
    assign out_ovf   = ovf_w[DIV_STEPS];
    assign out_side  = side_w[DIV_STEPS];

endmodule

@@ sim/gou_update_checker.sv @@
// Watches the configuration, gradient and update channels, predicts every
// update item and compares it with what the block sends.
module gou_update_checker
    import gou_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    gou_cfg_if   cfg,
    gou_in_if    grad,
    gou_out_if   upd,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] amount;
        logic              sat;
    } update_item_t;

    update_item_t          expected_updates[$];
    logic [DATA_W-1:0]     velocity_mem[PARAM_COUNT];
    logic [DATA_W-1:0]     sqavg_mem[PARAM_COUNT];
    mode_t                 cur_mode;
    logic [FRAC_W-1:0]     cur_lr;
    logic [FRAC_W-1:0]     cur_decay;

    // Floor square root of a 64-bit value, two bits per step
    function automatic longint unsigned floor_sqrt(input longint unsigned val);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= root + bitv)
            begin
                val  = val - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Advance the optimizer state of one parameter and form its update
    function automatic update_item_t optimizer_step(input logic [IDX_W-1:0] idx,
                                                    input logic [DATA_W-1:0] g_bits);
        update_item_t    res;
        longint          g;
        longint          b;
        longint          nb;
        longint          lr;
        longint          vel;
        longint          x;
        longint          amt;
        longint unsigned sqavg;
        longint unsigned sq;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned quo;
        logic            sat;
        g     = longint'($signed(g_bits));
        b     = longint'(cur_decay);
        nb    = 65536 - b;
        lr    = longint'(cur_lr);
        vel   = longint'($signed(velocity_mem[idx]));
        sqavg = longint'(sqavg_mem[idx]);
        sat   = 1'b0;
        if (cur_mode == MODE_MOMENTUM || cur_mode == MODE_ADAM)
        begin
            vel = (b * vel + nb * g + 32768) >>> 16;
            velocity_mem[idx] = vel[DATA_W-1:0];
        end
        if (cur_mode == MODE_RMSPROP || cur_mode == MODE_ADAM)
        begin
            mag = (g < 0) ? -g : g;
            sq  = (mag * mag) >> 24;
            if (sq > 64'hFFFF_FFFF)
            begin
                sq  = 64'hFFFF_FFFF;
                sat = 1'b1;
            end
            sqavg = (b * sqavg + nb * sq + 32768) >> 16;
            sqavg_mem[idx] = sqavg[DATA_W-1:0];
        end
        if (cur_mode == MODE_SGD)
            amt = (lr * g + 32768) >>> 16;
        else if (cur_mode == MODE_MOMENTUM)
            amt = (lr * vel + 32768) >>> 16;
        else
        begin
            x   = (cur_mode == MODE_RMSPROP) ? g : vel;
            den = floor_sqrt(sqavg << 24) + 1;
            mag = ((x < 0) ? -x : x) * lr * 256;
            quo = (mag + den / 2) / den;
            if (x < 0)
            begin
                if (quo > 64'h8000_0000)
                begin
                    quo = 64'h8000_0000;
                    sat = 1'b1;
                end
                amt = -longint'(quo);
            end
            else
            begin
                if (quo > 64'h7FFF_FFFF)
                begin
                    quo = 64'h7FFF_FFFF;
                    sat = 1'b1;
                end
                amt = longint'(quo);
            end
        end
        res.idx    = idx;
        res.amount = amt[DATA_W-1:0];
        res.sat    = sat;
        return res;
    endfunction

    assign pending = expected_updates.size();

    initial
    begin
        fail_count = 0;
        cur_mode   = MODE_RESET;
        cur_lr     = LEARN_RATE_RESET;
        cur_decay  = DECAY_RESET;
        for (int i = 0; i < PARAM_COUNT; i++)
        begin
            velocity_mem[i] = '0;
            sqavg_mem[i]    = '0;
        end
    end

    always @(posedge clk)
    begin
        update_item_t want;
        if (rst_n)
        begin
            // Track register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE:       cur_mode  = mode_t'(cfg.data[MODE_W-1:0]);
                    REG_LEARN_RATE: cur_lr    = cfg.data;
                    REG_DECAY:      cur_decay = cfg.data;
                    default: ;
                endcase
            end
            // Predict each accepted gradient item
            if (grad.valid && grad.ready)
                expected_updates.push_back(optimizer_step(grad.param_index, grad.gradient));
            // Compare each accepted update item with the oldest prediction
            if (upd.valid && upd.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected update item idx=%0d amount=%h sat=%b",
                                 $realtime, upd.out_index, upd.update_amount, upd.saturated);
                    fail_count++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (upd.out_index !== want.idx || upd.update_amount !== want.amount
                        || upd.saturated !== want.sat)
                    begin
                        if (fail_count < 10)
                            $display("%0t: mismatch exp idx=%0d amount=%h sat=%b, got idx=%0d amount=%h sat=%b",
                                     $realtime, want.idx, want.amount, want.sat,
                                     upd.out_index, upd.update_amount, upd.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

@@ sim/tb_gradient_optimizer_update.sv @@
module tb_gradient_optimizer_update
    import gou_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Register index outside the list, which the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SEGMENTS      = 12;
    localparam int RANDOM_ITEMS  = 95;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   src_idle;
    int   sink_idle;
    int   hold_left;
    bit   hold_req;
    int   stall_cycles;

    gou_cfg_if cfg_ch();
    gou_in_if  grad_ch();
    gou_out_if upd_ch();

    gradient_optimizer_update u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .grad  (grad_ch),
        .upd   (upd_ch)
    );

    gou_update_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .grad       (grad_ch),
        .upd        (upd_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            upd_ch.ready <= 1'b0;
        end
        else
            upd_ch.ready <= ($urandom_range(99) >= sink_idle);
    end

    // Watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((cfg_ch.valid && cfg_ch.ready) || (grad_ch.valid && grad_ch.ready)
            || (upd_ch.valid && upd_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_gradient(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] g);
        if ($urandom_range(99) < src_idle)
        begin
            grad_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        grad_ch.valid       <= 1'b1;
        grad_ch.param_index <= idx;
        grad_ch.gradient    <= g;
        @(posedge clk);
        while (!grad_ch.ready)
            @(posedge clk);
    endtask

    // Let every expected update arrive, then let the pipeline settle
    task automatic drain();
        grad_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] rand_gradient();
        logic [DATA_W-1:0] g;
        case ($urandom_range(9)) inside
            [0:3]:   g = $urandom;
            [4:6]:   g = $urandom_range(32'h0200_0000);
            7:       g = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: g = $urandom_range(2) - 1;
        endcase
        if ($urandom_range(1) && g[DATA_W-1] == 1'b0)
            g = -g;
        return g;
    endfunction

    initial
    begin
        logic [DATA_W-1:0] dir_grad[6];
        logic [IDX_W-1:0]  dir_idx[6];
        logic [FRAC_W-1:0] lr_val;
        logic [FRAC_W-1:0] decay_val;
        logic [IDX_W-1:0]  idx;
        dir_grad = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h0100_0000};
        dir_idx  = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd5, 12'd5};
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        grad_ch.valid       = 1'b0;
        grad_ch.param_index = '0;
        grad_ch.gradient    = '0;
        upd_ch.ready        = 1'b0;
        hold_req            = 1'b0;
        hold_left           = 0;
        stall_cycles        = 0;
        src_idle            = 31;
        sink_idle           = 53;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes at reset settings before any write
        for (int i = 0; i < 3; i++)
            send_gradient(dir_idx[i], dir_grad[i + 3]);
        drain();
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // Idling profile per phase
            if (seg == 4)
            begin
                src_idle  = 53;
                sink_idle = 31;
            end
            else if (seg == 8)
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            case (seg % 3)
                0:       lr_val = FRAC_W'($urandom);
                1:       lr_val = (seg < 6) ? 16'hFFFF : 16'h0000;
                default: lr_val = LEARN_RATE_RESET;
            endcase
            case ((seg / 3) % 3)
                0:       decay_val = FRAC_W'($urandom);
                1:       decay_val = 16'hFFFF;
                default: decay_val = 16'h0000;
            endcase
            drain();
            write_reg(REG_MODE, 16'(mode_t'(seg % 4)));
            write_reg(REG_LEARN_RATE, lr_val);
            write_reg(REG_DECAY, decay_val);

            // Directed extremes for each rule
            if (seg < 4)
                for (int i = 0; i < 6; i++)
                    send_gradient(dir_idx[i], dir_grad[i]);
            // Fill the block against a stalled receiver
            if (seg == 1)
                hold_req = 1'b1;
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                idx = ($urandom_range(3) == 0) ? 12'($urandom_range(4095))
                                               : 12'($urandom_range(7));
                send_gradient(idx, rand_gradient());
            end
        end

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gou_pkg.sv
hw/rtl/gou_if.sv
hw/rtl/gou_state.sv
hw/rtl/gou_sqrt.sv
hw/rtl/gou_div.sv
hw/rtl/gradient_optimizer_update.sv
sim/gou_update_checker.sv
sim/tb_gradient_optimizer_update.sv
